// ===== hdl/lcsl_pkg.sv =====
`default_nettype none

package lcsl_pkg;

   localparam int SYM_W = 8;
   localparam int LEN_W = 7;
   localparam logic [LEN_W-1:0] LEN_MAX = 7'd127;

   // Codes of the action field.
   localparam logic ACT_FIRST  = 1'b0;
   localparam logic ACT_SECOND = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/lcsl_ram.sv =====
`default_nettype none

module lcsl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/lcs_length_unit.sv =====
`default_nettype none

// Longest common subsequence length of two byte strings.
// Give one beat with start high while busy is low. A beat with action 0
// appends a byte of the first string to the store of MAX_LEN bytes; further
// bytes are dropped and the too_long flag of the pair is set. Busy stays
// low for such a beat. A beat with action 1 carries a byte of the second
// string and sweeps the stored score row, one entry per cycle, through a
// single compare and max unit fed by registered memory reads. Busy stays
// high while the N stored bytes (at most MAX_LEN) are swept and in the done
// state after the sweep. When that beat also has last set, the final busy
// cycle carries the result: rsp_strobe is high for one cycle with
// rsp_lcs_length and rsp_too_long, and the store, row and flag are then
// empty for the next pair. Lengths above 127 read as 127.
// The result is never held back: the receiver takes it in that cycle.
// Reset empties the pair; no clearing pass is needed because a row entry is
// zeroed when its byte is stored.
module lcs_length_unit #(
   parameter int MAX_LEN = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic                      req_action,
   input  wire logic [lcsl_pkg::SYM_W-1:0] req_symbol,
   input  wire logic                      req_last,
   output logic                           rsp_strobe,
   output logic [lcsl_pkg::LEN_W-1:0]     rsp_lcs_length,
   output logic                           rsp_too_long
);

   import lcsl_pkg::*;

   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int SCORE_W = CNT_W;
   localparam int WIDE_W = (SCORE_W > LEN_W) ? SCORE_W : LEN_W;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               trunc_ff, trunc_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]   wr_idx_ff;
   logic               have_ff, have_in;
   logic [SYM_W-1:0]   sym_ff;
   logic               last_ff;
   logic [SCORE_W-1:0] diag_ff, diag_in;
   logic [SCORE_W-1:0] left_ff, left_in;

   logic               accept;
   logic               append;
   logic               rd_en;
   logic [SYM_W-1:0]   fs_rd_data;
   logic [SCORE_W-1:0] up;
   logic [SCORE_W-1:0] val;
   logic               sr_wr_en;
   logic [IDX_W-1:0]   sr_wr_addr;
   logic [SCORE_W-1:0] sr_wr_data;
   logic [WIDE_W-1:0]  left_wide;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign append = accept && (req_action == ACT_FIRST) && (count_ff < CNT_W'(MAX_LEN));
   assign rd_en  = (state_ff == ST_RUN) && (rd_idx_ff < count_ff);

   lcsl_ram #(
      .WIDTH (SYM_W),
      .DEPTH (MAX_LEN)
   ) u_first_ram (
      .clock   (clock),
      .wr_en   (append),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_symbol),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (fs_rd_data)
   );

   lcsl_ram #(
      .WIDTH (SCORE_W),
      .DEPTH (MAX_LEN)
   ) u_score_ram (
      .clock   (clock),
      .wr_en   (sr_wr_en),
      .wr_addr (sr_wr_addr),
      .wr_data (sr_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (up)
   );

   // One cell of the recurrence: a match extends the diagonal, else the max.
   always_comb begin
      if (fs_rd_data == sym_ff) begin
         val = diag_ff + SCORE_W'(1);
      end else if (up > left_ff) begin
         val = up;
      end else begin
         val = left_ff;
      end
   end

   // A newly stored byte starts its column at zero.
   always_comb begin
      if (state_ff == ST_RUN && have_ff) begin
         sr_wr_en   = 1'b1;
         sr_wr_addr = wr_idx_ff;
         sr_wr_data = val;
      end else begin
         sr_wr_en   = append;
         sr_wr_addr = count_ff[IDX_W-1:0];
         sr_wr_data = '0;
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      trunc_in  = trunc_ff;
      rd_idx_in = rd_idx_ff;
      have_in   = 1'b0;
      diag_in   = diag_ff;
      left_in   = left_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACT_FIRST) begin
                  if (append) begin
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     trunc_in = 1'b1;
                  end
               end else begin
                  rd_idx_in = '0;
                  diag_in   = '0;
                  left_in   = '0;
                  state_in  = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (have_ff) begin
               diag_in = up;
               left_in = val;
            end
            if (rd_en) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
               have_in   = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (last_ff) begin
               count_in = '0;
               trunc_in = 1'b0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         trunc_ff <= 1'b0;
         have_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         trunc_ff <= trunc_in;
         have_ff  <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      wr_idx_ff <= rd_idx_ff[IDX_W-1:0];
      diag_ff   <= diag_in;
      left_ff   <= left_in;
      if (accept) begin
         sym_ff  <= req_symbol;
         last_ff <= req_last;
      end
   end

   assign left_wide  = WIDE_W'(left_ff);
   assign rsp_strobe = (state_ff == ST_DONE) && last_ff;
   assign rsp_too_long = trunc_ff;

   always_comb begin
      if (left_wide > WIDE_W'(LEN_MAX)) begin
         rsp_lcs_length = LEN_MAX;
      end else begin
         rsp_lcs_length = left_wide[LEN_W-1:0];
      end
   end

endmodule

`default_nettype wire
